// ----- rtl/eqc_pkg.sv -----
package eqc_pkg;

  // frame limits and field widths
  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned SQ_W       = 36;
  localparam int unsigned VAR_W      = 22;
  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned STATUS_W   = 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;

  // shared divider and multiplier
  localparam int unsigned REM_W   = CNT_W;
  localparam int unsigned DIVQ_W  = 22;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned MUL_A_W = 29;
  localparam int unsigned MUL_B_W = 22;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned OUT_DATA_W = 80;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_UPPER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_LOWER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_THRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNDER_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_RATIO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_RATIO   = 3'd6;

  // register reset values
  localparam logic [7:0]         RST_MEAN_UPPER  = 8'd200;
  localparam logic [7:0]         RST_MEAN_LOWER  = 8'd50;
  localparam logic [VAR_W-1:0]   RST_VAR_THRESH  = 22'd25600;
  localparam logic [7:0]         RST_OVER_LIMIT  = 8'd250;
  localparam logic [7:0]         RST_UNDER_LIMIT = 8'd5;
  localparam logic [RATIO_W-1:0] RST_HIGH_RATIO  = 17'd3277;
  localparam logic [RATIO_W-1:0] RST_LOW_RATIO   = 17'd3277;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BRIGHT_HIGH = 3'd1,
    ST_BRIGHT_LOW  = 3'd2,
    ST_TEXTURE_LOW = 3'd3,
    ST_SAT_HIGH    = 3'd4,
    ST_SAT_LOW     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_MEAN,
    S_MEAN,
    S_MN,
    S_MS,
    S_MT,
    S_DEV,
    S_START_VAR,
    S_VAR,
    S_THR,
    S_CT,
    S_CH,
    S_CL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] over;
    logic [CNT_W-1:0] under;
    logic             ovf;
  } acc_t;

  typedef struct packed {
    logic [7:0]         mean_upper;
    logic [7:0]         mean_lower;
    logic [VAR_W-1:0]   texture_limit;
    logic [7:0]         over_limit;
    logic [7:0]         under_limit;
    logic [RATIO_W-1:0] high_ratio;
    logic [RATIO_W-1:0] low_ratio;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

// ----- rtl/image_exposure_quality_check_top.sv -----
// channel  direction  handshake           payload
// s        in         s_tvalid/s_tready   s_tdata: pixel; s_tlast: last_pixel
// m        out        m_tvalid/m_tready   m_tdata: status..frame_overflow
// cfg      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// pixels are taken one per cycle while the frame runs
// after the last pixel the block drops s_tready while it runs an
// 8-step divide for the mean, two multiplies, a 22-step divide for the
// variance and three threshold compares, all on one divider and one multiplier
// a result waiting on m_tready holds s_tready low only once the next frame ends
// synchronous reset restores register defaults and clears the frame sums
module image_exposure_quality_check_top import eqc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,    // [7:0] pixel
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [2:0] status, [10:3] mean_value, [32:11] variance_q8, [53:33] high_count,
  // [74:54] low_count, [75] frame_overflow, [79:76] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t               cfg;
  state_t             state;
  state_t             state_next;
  acc_t               acc;
  logic               take;
  logic               acc_clear;
  logic               load;
  div_ctl_t           div_ctl;
  logic [REM_W-1:0]   div_rem_init;
  logic [DIVQ_W-1:0]  div_lo_init;
  logic               div_done;
  logic [DIVQ_W-1:0]  div_quot;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [7:0]         mean;
  logic [MUL_A_W-1:0] twice_sum_less;
  logic [SQ_W-1:0]    dev;
  logic [VAR_W-1:0]   variance;
  logic               tex_low;
  logic               sat_hi;
  logic               sat_lo;
  status_t            status;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign take      = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mean_upper    <= RST_MEAN_UPPER;
      cfg.mean_lower    <= RST_MEAN_LOWER;
      cfg.texture_limit <= RST_VAR_THRESH;
      cfg.over_limit    <= RST_OVER_LIMIT;
      cfg.under_limit   <= RST_UNDER_LIMIT;
      cfg.high_ratio    <= RST_HIGH_RATIO;
      cfg.low_ratio     <= RST_LOW_RATIO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEAN_UPPER:  cfg.mean_upper    <= cfg_data[7:0];
        REG_MEAN_LOWER:  cfg.mean_lower    <= cfg_data[7:0];
        REG_VAR_THRESH:  cfg.texture_limit <= cfg_data[VAR_W-1:0];
        REG_OVER_LIMIT:  cfg.over_limit    <= cfg_data[7:0];
        REG_UNDER_LIMIT: cfg.under_limit   <= cfg_data[7:0];
        REG_HIGH_RATIO:  cfg.high_ratio    <= cfg_data[RATIO_W-1:0];
        REG_LOW_RATIO:   cfg.low_ratio     <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // frame accumulators
  eqc_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .pixel       (s_tdata),
    .over_limit  (cfg.over_limit),
    .under_limit (cfg.under_limit),
    .clear       (acc_clear),
    .acc         (acc)
  );

  // shared divider
  eqc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .lo_init  (div_lo_init),
    .divisor  (acc.cnt),
    .done     (div_done),
    .quot     (div_quot)
  );

  // shared multiplier
  eqc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, divider and multiplier operands
  always_comb begin
    state_next   = state;
    div_ctl      = '0;
    div_rem_init = '0;
    div_lo_init  = '0;
    mul_a        = '0;
    mul_b        = '0;
    acc_clear    = 1'b0;
    load         = 1'b0;
    case (state)
      S_IDLE: begin
        if (take && s_tlast) begin
          state_next = S_START_MEAN;
        end
      end
      S_START_MEAN: begin
        // mean = sum / n, quotient known to fit in 8 bits
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(8);
        div_rem_init  = REM_W'(acc.sum[SUM_W-1:8]);
        div_lo_init   = {acc.sum[7:0], 14'b0};
        state_next    = S_MEAN;
      end
      S_MEAN: begin
        if (div_done) begin
          state_next = S_MN;
        end
      end
      S_MN: begin
        mul_a      = MUL_A_W'(mean);
        mul_b      = MUL_B_W'(acc.cnt);
        state_next = S_MS;
      end
      S_MS: begin
        state_next = S_MT;
      end
      S_MT: begin
        mul_a      = twice_sum_less;
        mul_b      = MUL_B_W'(mean);
        state_next = S_DEV;
      end
      S_DEV: begin
        state_next = S_START_VAR;
      end
      S_START_VAR: begin
        // variance = (dev * 256) / n, quotient below 2^22
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(DIVQ_W);
        div_rem_init  = dev[34:14];
        div_lo_init   = {dev[13:0], 8'b0};
        state_next    = S_VAR;
      end
      S_VAR: begin
        if (div_done) begin
          state_next = S_THR;
        end
      end
      S_THR: begin
        mul_a      = MUL_A_W'(cfg.texture_limit);
        mul_b      = MUL_B_W'(acc.cnt);
        state_next = S_CT;
      end
      S_CT: begin
        mul_a      = MUL_A_W'(cfg.high_ratio);
        mul_b      = MUL_B_W'(acc.cnt);
        state_next = S_CH;
      end
      S_CH: begin
        mul_a      = MUL_A_W'(cfg.low_ratio);
        mul_b      = MUL_B_W'(acc.cnt);
        state_next = S_CL;
      end
      S_CL: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          acc_clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // intermediate results of the frame-end sequence
  always_ff @(posedge clk) begin
    case (state)
      S_MEAN: begin
        if (div_done) begin
          mean <= (acc.cnt == '0) ? 8'd0 : div_quot[7:0];
        end
      end
      S_MS: twice_sum_less <= {acc.sum, 1'b0} - mul_p[MUL_A_W-1:0];
      S_DEV: dev <= acc.sq - mul_p[SQ_W-1:0];
      S_VAR: begin
        if (div_done) begin
          variance <= (acc.cnt == '0) ? '0 : div_quot;
        end
      end
      S_CT: tex_low <= {dev, 8'b0} < {1'b0, mul_p[42:0]};
      S_CH: sat_hi <= {1'b0, acc.over, 16'b0} > mul_p[37:0];
      S_CL: sat_lo <= {1'b0, acc.under, 16'b0} > mul_p[37:0];
      default: ;
    endcase
  end

  // status by priority
  always_comb begin
    if (mean > cfg.mean_upper) begin
      status = ST_BRIGHT_HIGH;
    end else if (mean < cfg.mean_lower) begin
      status = ST_BRIGHT_LOW;
    end else if (tex_low) begin
      status = ST_TEXTURE_LOW;
    end else if (sat_hi) begin
      status = ST_SAT_HIGH;
    end else if (sat_lo) begin
      status = ST_SAT_LOW;
    end else begin
      status = ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'b0, acc.ovf, acc.under, acc.over, variance, mean, status};
    end
  end

`ifndef SYNTHESIS
  // a frame end stops intake on the next cycle
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("intake not stopped after frame end");

  // a new result appears only from the output state
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT)
    else $error("result raised outside output state");

  // divider finishes only while the sequencer waits for it
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MEAN || state == S_VAR))
    else $error("divider done while not awaited");

  // pixel count never passes the frame limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    acc.cnt <= CNT_W'(MAX_PIXELS))
    else $error("pixel count beyond frame limit");
`endif

endmodule

// ----- rtl/eqc_accum.sv -----
module eqc_accum import eqc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [PIX_W-1:0] pixel,
  input  logic [7:0]       over_limit,
  input  logic [7:0]       under_limit,
  input  logic             clear,
  output acc_t             acc
);

  logic [2*PIX_W-1:0] pix_sq;

  // square of the incoming pixel
  assign pix_sq = (2*PIX_W)'(pixel) * (2*PIX_W)'(pixel);

  // per-frame accumulators, saturating at the frame limit
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
    end else if (take) begin
      if (acc.cnt < CNT_W'(MAX_PIXELS)) begin
        acc.cnt <= acc.cnt + 1'b1;
        acc.sum <= acc.sum + SUM_W'(pixel);
        acc.sq  <= acc.sq + SQ_W'(pix_sq);
        if (pixel > over_limit) begin
          acc.over <= acc.over + 1'b1;
        end
        if (pixel < under_limit) begin
          acc.under <= acc.under + 1'b1;
        end
      end else begin
        acc.ovf <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/eqc_div.sv -----
module eqc_div import eqc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_ctl_t          ctl,
  input  logic [REM_W-1:0]  rem_init,
  input  logic [DIVQ_W-1:0] lo_init,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [DIVQ_W-1:0] quot
);

  logic              busy;
  logic [STEP_W-1:0] left;
  logic [REM_W-1:0]  rem;
  logic [DIVQ_W-1:0] lo;
  logic [REM_W:0]    shifted;
  logic [REM_W:0]    diff;
  logic              fits;
  logic [REM_W-1:0]  rem_next;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    shifted  = {rem, lo[DIVQ_W-1]};
    diff     = shifted - {1'b0, divisor};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        left <= ctl.steps;
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder, dividend and quotient shift registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= rem_init;
      lo   <= lo_init;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      lo   <= {lo[DIVQ_W-2:0], 1'b0};
      quot <= {quot[DIVQ_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/eqc_mul.sv -----
module eqc_mul import eqc_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  // registered product
  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule
